FILE: rtl/mrfc_pkg.sv
// Package for the Modbus RTU frame codec: result types, codes and the CRC-16 step.
`timescale 1ns / 1ps
package mrfc_pkg;

    // Operation codes of an input transaction
    localparam logic OP_TX = 1'b0;
    localparam logic OP_RX = 1'b1;

    // Result kinds
    localparam logic KIND_TX_BYTE = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_FRAME = 2'd1;
    localparam logic [1:0] STATUS_ADDR_MISS = 2'd2;
    localparam logic [1:0] STATUS_EXCEPTION = 2'd3;

    // CRC-16/Modbus, reflected form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Slave address after reset
    localparam logic [7:0] SLAVE_ADDR_RESET = 8'd1;

    // One input transaction produces at most this many results
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic       result_kind;
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] frame_status;
        logic [7:0] pdu_length;
        logic [7:0] function_code;
        logic [7:0] except_code;
    } mrfc_result_t;

    // Results of one input transaction, loaded into the output queue at once
    typedef struct packed {
        logic                            load;
        logic [RES_CNT_W-1:0]            count;
        mrfc_result_t [MAX_RESULTS-1:0]  entries;
    } mrfc_burst_t;

    // Fold one byte into the CRC, one bit per step
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic mrfc_result_t tx_result(input logic [7:0] b, input logic last);
        mrfc_result_t r;
        r                = '0;
        r.result_kind    = KIND_TX_BYTE;
        r.out_byte       = b;
        r.out_last       = last;
        return r;
    endfunction

endpackage

FILE: rtl/mrfc_if.sv
// Channel interfaces of the Modbus RTU frame codec: input items, results, configuration.
`timescale 1ns / 1ps
interface mrfc_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output operation, output data_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input last_byte,
                    output ready);
endinterface

interface mrfc_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] frame_status;
    logic [7:0] pdu_length;
    logic [7:0] function_code;
    logic [7:0] except_code;

    modport source (output valid, output result_kind, output out_byte, output out_last,
                    output frame_status, output pdu_length, output function_code,
                    output except_code, input ready);
    modport sink   (input valid, input result_kind, input out_byte, input out_last,
                    input frame_status, input pdu_length, input function_code,
                    input except_code, output ready);
endinterface

interface mrfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/mrfc_result_queue.sv
// Result queue: holds the results of one input transaction and hands them out in order.
`timescale 1ns / 1ps
module mrfc_result_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  mrfc_pkg::mrfc_burst_t burst,
    output logic                take_ready,
    mrfc_out_if.source          out_ch
);
    import mrfc_pkg::*;

    mrfc_result_t [MAX_RESULTS-1:0] entries_reg;
    logic [RES_CNT_W-1:0]           count_reg;
    logic [RES_IDX_W-1:0]           idx_reg;
    logic                           at_final;
    logic                           out_fire;
    mrfc_result_t                   head;

    // Decode the position of the head entry
    assign at_final   = (RES_CNT_W'(idx_reg) + RES_CNT_W'(1)) == count_reg;
    assign out_fire   = out_ch.valid && out_ch.ready;
    assign take_ready = (count_reg == '0) || (out_ch.ready && at_final);

    // Load a new burst or advance through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (burst.load)
        begin
            count_reg <= burst.count;
            idx_reg   <= '0;
        end
        else if (out_fire)
        begin
            if (at_final)
                count_reg <= '0;
            else
                idx_reg <= idx_reg + RES_IDX_W'(1);
        end
    end

    // Hold the payload of the burst
    always_ff @(posedge clk)
    begin
        if (burst.load)
            entries_reg <= burst.entries;
    end

    // Drive the head entry onto the result channel
    assign head                  = entries_reg[idx_reg];
    assign out_ch.valid          = (count_reg != '0);
    assign out_ch.result_kind    = head.result_kind;
    assign out_ch.out_byte       = head.out_byte;
    assign out_ch.out_last       = head.out_last;
    assign out_ch.frame_status   = head.frame_status;
    assign out_ch.pdu_length     = head.pdu_length;
    assign out_ch.function_code  = head.function_code;
    assign out_ch.except_code    = head.except_code;

endmodule

FILE: rtl/modbus_rtu_frame_codec_unit.sv
// Top level of the Modbus RTU master frame codec: framing, CRC-16 and reply checking.
`timescale 1ns / 1ps
// Usage:
//   in_ch  - one transaction per byte: operation 0 carries a PDU byte to send,
//            operation 1 a received frame byte; last_byte marks the end.
//   out_ch - result transactions: sent frame bytes (slave address first, CRC low
//            then high after the last PDU byte) or one verdict per received frame.
//   cfg    - write of the slave address; always ready. Write only while idle.
// Timing: an accepted byte is folded into the CRC in the accept cycle and its
//   results appear on out_ch the next cycle, one per cycle while out_ch is
//   ready. A byte that yields one result or none is followed by the next
//   byte in the next cycle if out_ch is ready. The first PDU byte of a frame
//   yields two results and the last one three (four for a one-byte PDU);
//   in_ch holds ready low until the final queued result is taken, so the
//   next byte waits for them; the one-result-per-cycle port sets throughput.
// Stall: when out_ch is not ready the queued results hold and in_ch stays
//   blocked once results are pending; nothing is dropped.
// Reset: clears the frame state, the result queue and sets slave address 1.
module modbus_rtu_frame_codec_unit #(
    parameter int MAX_FRAME = 256,
    parameter int MIN_FRAME = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    mrfc_in_if.sink     in_ch,
    mrfc_out_if.source  out_ch,
    mrfc_cfg_if.sink    cfg
);
    import mrfc_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAME + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME);

    logic [7:0]       slave_addr_reg;
    logic [15:0]      addr_crc_reg;
    logic [15:0]      crc_reg,        crc_next;
    logic [CNT_W-1:0] count_reg,      count_next;
    logic [7:0]       frame_addr_reg, frame_addr_next;
    logic [7:0]       func_reg,       func_next;
    logic [7:0]       second_reg,     second_next;
    logic             tx_frame_reg,   tx_frame_next;

    logic             in_fire;
    logic             take_ready;
    mrfc_burst_t      burst;

    logic [15:0]      crc_base;
    logic [15:0]      crc_new;
    logic [CNT_W-1:0] count_base;
    logic [CNT_W-1:0] count_inc;
    logic             bad_frame;
    logic [CNT_W-1:0] pdu_len_wide;
    mrfc_result_t     verdict;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = take_ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Hold the slave address and its CRC prefix for the start of a sent frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= SLAVE_ADDR_RESET;
            addr_crc_reg   <= crc_fold(CRC_INIT, SLAVE_ADDR_RESET);
        end
        else if (cfg.valid)
        begin
            slave_addr_reg <= cfg.data;
            addr_crc_reg   <= crc_fold(CRC_INIT, cfg.data);
        end
    end

    // Pick the CRC starting point and fold in the byte
    always_comb
    begin
        if (in_ch.operation == OP_TX)
            crc_base = tx_frame_reg ? crc_reg : addr_crc_reg;
        else
            crc_base = tx_frame_reg ? CRC_INIT : crc_reg;
        crc_new    = crc_fold(crc_base, in_ch.data_byte);
        count_base = tx_frame_reg ? '0 : count_reg;
        count_inc  = (count_base <= CNT_MAX) ? count_base + CNT_W'(1) : count_base;
    end

    // Capture the address and the first two PDU bytes of a received frame
    always_comb
    begin
        frame_addr_next = tx_frame_reg ? 8'h00 : frame_addr_reg;
        func_next       = tx_frame_reg ? 8'h00 : func_reg;
        second_next     = tx_frame_reg ? 8'h00 : second_reg;
        if (in_ch.operation == OP_TX)
        begin
            frame_addr_next = 8'h00;
            func_next       = 8'h00;
            second_next     = 8'h00;
        end
        else
        begin
            if (count_base == CNT_W'(0))
                frame_addr_next = in_ch.data_byte;
            if (count_base == CNT_W'(1))
                func_next = in_ch.data_byte;
            if (count_base == CNT_W'(2))
                second_next = in_ch.data_byte;
        end
    end

    // Build the receive verdict from the updated frame state
    always_comb
    begin
        bad_frame    = (count_inc > CNT_MAX) || (count_inc < CNT_MIN)
                       || (count_inc < CNT_W'(3)) || (crc_new != 16'h0000);
        pdu_len_wide = count_inc - CNT_W'(3);
        verdict             = '0;
        verdict.result_kind = KIND_VERDICT;
        verdict.out_last    = 1'b1;
        if (bad_frame)
            verdict.frame_status = STATUS_BAD_FRAME;
        else
        begin
            verdict.pdu_length = 8'(pdu_len_wide);
            if (pdu_len_wide >= CNT_W'(1))
                verdict.function_code = func_next;
            if ((pdu_len_wide >= CNT_W'(2)) && func_next[7])
                verdict.except_code = second_next;
            priority if (frame_addr_next != slave_addr_reg)
                verdict.frame_status = STATUS_ADDR_MISS;
            else if ((pdu_len_wide >= CNT_W'(1)) && func_next[7])
                verdict.frame_status = STATUS_EXCEPTION;
            else
                verdict.frame_status = STATUS_OK;
        end
    end

    // Compute the next frame state and the burst of results
    always_comb
    begin
        crc_next        = crc_reg;
        count_next      = count_reg;
        tx_frame_next   = tx_frame_reg;
        burst           = '0;
        burst.load      = in_fire;

        unique case (in_ch.operation)
            OP_TX:
            begin
                count_next      = '0;
                if (!tx_frame_reg)
                begin
                    burst.entries[0] = tx_result(slave_addr_reg, 1'b0);
                    burst.entries[1] = tx_result(in_ch.data_byte, 1'b0);
                    burst.entries[2] = tx_result(crc_new[7:0], 1'b0);
                    burst.entries[3] = tx_result(crc_new[15:8], 1'b1);
                    burst.count      = in_ch.last_byte ? RES_CNT_W'(4) : RES_CNT_W'(2);
                end
                else
                begin
                    burst.entries[0] = tx_result(in_ch.data_byte, 1'b0);
                    burst.entries[1] = tx_result(crc_new[7:0], 1'b0);
                    burst.entries[2] = tx_result(crc_new[15:8], 1'b1);
                    burst.count      = in_ch.last_byte ? RES_CNT_W'(3) : RES_CNT_W'(1);
                end
                if (in_ch.last_byte)
                begin
                    crc_next      = CRC_INIT;
                    tx_frame_next = 1'b0;
                end
                else
                begin
                    crc_next      = crc_new;
                    tx_frame_next = 1'b1;
                end
            end
            OP_RX:
            begin
                tx_frame_next = 1'b0;
                if (in_ch.last_byte)
                begin
                    burst.entries[0] = verdict;
                    burst.count      = RES_CNT_W'(1);
                    crc_next         = CRC_INIT;
                    count_next       = '0;
                end
                else
                begin
                    crc_next   = crc_new;
                    count_next = count_inc;
                end
            end
            default:
            begin
                burst.load = 1'b0;
            end
        endcase
    end

    // Advance the frame state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg        <= CRC_INIT;
            count_reg      <= '0;
            frame_addr_reg <= 8'h00;
            func_reg       <= 8'h00;
            second_reg     <= 8'h00;
            tx_frame_reg   <= 1'b0;
        end
        else if (in_fire)
        begin
            crc_reg        <= crc_next;
            count_reg      <= count_next;
            tx_frame_reg   <= tx_frame_next;
            if (in_ch.last_byte)
            begin
                frame_addr_reg <= 8'h00;
                func_reg       <= 8'h00;
                second_reg     <= 8'h00;
            end
            else
            begin
                frame_addr_reg <= frame_addr_next;
                func_reg       <= func_next;
                second_reg     <= second_next;
            end
        end
    end

    mrfc_result_queue u_result_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .burst      (burst),
        .take_ready (take_ready),
        .out_ch     (out_ch)
    );

endmodule
